@@ rtl/core/czs_pkg.sv @@
// ----------------------------------------------------------------------------
// czs_pkg: shared types and helpers for the zero-square counter
// Field widths, register indexes, result word layout and small arithmetic
// helpers used by the interfaces and the datapath.
// ----------------------------------------------------------------------------
package czs_pkg;

	// Fixed field widths.
	localparam int CNT_W   = 12;
	localparam int TOTAL_W = 32;
	localparam int CFG_W   = 12;

	// Defaults for the grid size parameters and the register reset value.
	localparam int MAX_COLS_DEF = 2048;
	localparam int MAX_ROWS_DEF = 2048;
	localparam int CFG_RESET    = 2048;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Register indexes of the configuration port.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

	// Per-cell control flags carried through the first pipeline stage.
	typedef struct packed {
		logic dmg;
		logic col_gt0;
		logic row_gt0;
		logic last_col;
		logic last_row;
		logic byp;
	} czs_flags_t;

	// One line buffer entry: square count and upward run of a column.
	typedef struct packed {
		logic [CNT_W-1:0] squares;
		logic [CNT_W-1:0] up_run;
	} czs_line_t;

	// One result word.
	typedef struct packed {
		logic [CNT_W-1:0]   squares_here;
		logic [TOTAL_W-1:0] running_total;
		logic               frame_done;
	} czs_result_t;

	// Saturating increment of a count or run.
	function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	// Minimum of three counts.
	function automatic logic [CNT_W-1:0] min3(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b, input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	// Register value to size: zero acts as one, values above the maximum as the maximum.
	function automatic logic [31:0] clamp_cfg(input logic [CFG_W-1:0] v,
			input int unsigned maxv);
		logic [31:0] wide;
		wide = 32'(v);
		if (wide == 32'd0) return 32'd1;
		if (wide > maxv) return maxv;
		return wide;
	endfunction

endpackage

@@ rtl/core/czs_if.sv @@
// ----------------------------------------------------------------------------
// czs_in_if / czs_out_if: stream channels of the zero-square counter
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface czs_in_if;
	logic valid;
	logic ready;
	logic damaged;

	modport source (output valid, output damaged, input ready);
	modport sink (input valid, input damaged, output ready);
endinterface

interface czs_out_if;
	import czs_pkg::*;
	logic               valid;
	logic               ready;
	logic [CNT_W-1:0]   squares_here;
	logic [TOTAL_W-1:0] running_total;
	logic               frame_done;

	modport source (output valid, output squares_here, output running_total,
		output frame_done, input ready);
	modport sink (input valid, input squares_here, input running_total,
		input frame_done, output ready);
endinterface

@@ rtl/core/czs_ram.sv @@
// ----------------------------------------------------------------------------
// czs_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module czs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/czs_cell.sv @@
// ----------------------------------------------------------------------------
// czs_cell: elastic register cell of the pipeline chain
// Holds one word and hands it to its neighbor; takes a new word whenever
// it is empty or its word leaves in the same cycle.
// ----------------------------------------------------------------------------
module czs_cell #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	logic             valid_q;
	logic [WIDTH-1:0] data_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	// Occupancy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Word register.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= in_data;
		end
	end

endmodule

@@ rtl/core/count_zero_squares_stream.sv @@
// ----------------------------------------------------------------------------
// count_zero_squares_stream: streaming count of all-intact squares
// A taken grid word is held in the lookup cell; its result word is computed
// from it and registered into the result cell, which offers it downstream.
// Throughput: one grid word per cycle unless the result port stalls, set by
// the line buffer's one read port and one write port, both used once per word.
// Reset clears position, totals and the row state; the line buffer is not
// cleared, since the first row of every frame never uses its data.
// ----------------------------------------------------------------------------
module count_zero_squares_stream #(
	parameter int MAX_COLS = czs_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = czs_pkg::MAX_ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	czs_in_if.sink                        grid_in,
	czs_out_if.source                     count_out,
	input  logic                          cfg_we,
	input  logic [czs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [czs_pkg::CFG_W-1:0]     cfg_wdata
);
	import czs_pkg::*;

	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int CCFG_W = $clog2(MAX_COLS + 1);
	localparam int RCFG_W = $clog2(MAX_ROWS + 1);
	localparam int LINE_W = $bits(czs_line_t);
	localparam int S1_W   = $bits(czs_flags_t) + COL_W + LINE_W;
	localparam int RES_W  = $bits(czs_result_t);
	localparam logic [CCFG_W-1:0] COLS_RST =
		CCFG_W'((CFG_RESET > MAX_COLS) ? MAX_COLS : CFG_RESET);
	localparam logic [RCFG_W-1:0] ROWS_RST =
		RCFG_W'((CFG_RESET > MAX_ROWS) ? MAX_ROWS : CFG_RESET);

	logic [RCFG_W-1:0] rows_q;
	logic [CCFG_W-1:0] cols_q;
	logic [COL_W-1:0]  col_pos_q;
	logic [ROW_W-1:0]  row_pos_q;
	logic [CNT_W-1:0]  diag_q;
	logic [CNT_W-1:0]  left_q;
	logic [TOTAL_W-1:0] total_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RST;
			cols_q <= COLS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROWS: rows_q <= RCFG_W'(clamp_cfg(cfg_wdata, MAX_ROWS));
				REG_COLS: cols_q <= CCFG_W'(clamp_cfg(cfg_wdata, MAX_COLS));
				default: ;
			endcase
		end
	end

	// Handshake signals of the two cells.
	logic s1_in_ready, s1_valid, out_in_ready;
	logic accept, s1_adv;
	logic [S1_W-1:0] s1_in_data, s1_data;

	assign accept = grid_in.valid && s1_in_ready;
	assign grid_in.ready = s1_in_ready;
	assign s1_adv = s1_valid && out_in_ready;

	// Position of the incoming word and its row and frame end flags.
	logic [CCFG_W:0] col_next;
	logic [RCFG_W:0] row_next;
	logic            last_col, last_row;

	assign col_next = (CCFG_W + 1)'(col_pos_q) + 1'b1;
	assign row_next = (RCFG_W + 1)'(row_pos_q) + 1'b1;
	assign last_col = col_next >= (CCFG_W + 1)'(cols_q);
	assign last_row = row_next >= (RCFG_W + 1)'(rows_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_pos_q <= '0;
			row_pos_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_pos_q <= '0;
				row_pos_q <= last_row ? '0 : row_pos_q + 1'b1;
			end else begin
				col_pos_q <= col_pos_q + 1'b1;
			end
		end
	end

	// Datapath of the word in the first cell, written back as it leaves.
	czs_flags_t       in_flags, s1_flags;
	logic [COL_W-1:0] s1_addr;
	czs_line_t        s1_byp, rd_line, up_line, wr_line;
	logic [CNT_W-1:0] up_sq, up_run, diag, left, here, run_left;
	czs_result_t      res;

	assign {s1_flags, s1_addr, s1_byp} = s1_data;

	always_comb begin
		up_line  = s1_flags.byp ? s1_byp : rd_line;
		up_sq    = s1_flags.row_gt0 ? up_line.squares : '0;
		up_run   = s1_flags.row_gt0 ? up_line.up_run : '0;
		diag     = (s1_flags.row_gt0 && s1_flags.col_gt0) ? diag_q : '0;
		left     = s1_flags.col_gt0 ? left_q : '0;
		here     = '0;
		run_left = '0;
		wr_line  = '0;
		if (!s1_flags.dmg) begin
			here           = inc_sat(min3(diag, up_run, left));
			run_left       = inc_sat(left);
			wr_line.up_run = inc_sat(up_run);
		end
		wr_line.squares   = here;
		res.squares_here  = here;
		res.running_total = total_q + TOTAL_W'(here);
		res.frame_done    = s1_flags.last_col && s1_flags.last_row;
	end

	// A read that meets the write of the same column takes the write data.
	always_comb begin
		in_flags          = '0;
		in_flags.dmg      = grid_in.damaged;
		in_flags.col_gt0  = col_pos_q != '0;
		in_flags.row_gt0  = row_pos_q != '0;
		in_flags.last_col = last_col;
		in_flags.last_row = last_row;
		in_flags.byp      = s1_adv && (s1_addr == col_pos_q);
		s1_in_data        = {in_flags, col_pos_q, wr_line};
	end

	// Row state: diagonal neighbor, leftward run and frame total.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diag_q  <= '0;
			left_q  <= '0;
			total_q <= '0;
		end else if (s1_adv) begin
			diag_q  <= s1_flags.last_col ? '0 : up_sq;
			left_q  <= s1_flags.last_col ? '0 : run_left;
			total_q <= res.frame_done ? '0 : res.running_total;
		end
	end

	// Line buffer of the previous row.
	czs_ram #(
		.WIDTH (LINE_W),
		.DEPTH (MAX_COLS)
	) u_line (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (s1_addr),
		.wdata (wr_line),
		.re    (accept),
		.raddr (col_pos_q),
		.rdata (rd_line)
	);

	// Pipeline chain: lookup cell, then result cell.
	czs_cell #(
		.WIDTH (S1_W)
	) u_cell_s1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (grid_in.valid),
		.in_ready  (s1_in_ready),
		.in_data   (s1_in_data),
		.out_valid (s1_valid),
		.out_ready (out_in_ready),
		.out_data  (s1_data)
	);

	czs_result_t out_res;
	logic [RES_W-1:0] out_data;

	assign out_res                 = out_data;
	assign count_out.squares_here  = out_res.squares_here;
	assign count_out.running_total = out_res.running_total;
	assign count_out.frame_done    = out_res.frame_done;

	czs_cell #(
		.WIDTH (RES_W)
	) u_cell_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s1_valid),
		.in_ready  (out_in_ready),
		.in_data   (res),
		.out_valid (count_out.valid),
		.out_ready (count_out.ready),
		.out_data  (out_data)
	);

	// The column position never leaves the line buffer.
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		col_pos_q <= COL_W'(MAX_COLS - 1))
		else $error("column position beyond line buffer");

	// A stalled lookup word keeps its line buffer data.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !out_in_ready |=> $stable(rd_line) && $stable(s1_data))
		else $error("stalled word lost its line buffer data");

	// The total restarts after the last word of a frame.
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && res.frame_done |=> total_q == '0)
		else $error("frame total did not restart");

	// A read that meets the write of the same column takes the bypass.
	a_byp_addr: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s1_adv && (s1_addr == col_pos_q) |=> s1_flags.byp)
		else $error("missed write to read forwarding");

endmodule

@@ verif/tb_count_zero_squares_stream.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_count_zero_squares_stream: self-checking bench for the square counter
// Streams binary grids through the block under random handshake gaps and
// grid sizes. Each taken grid word is run through a local predictor of the
// square count, the running total and the frame flag. Each result word is
// checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_count_zero_squares_stream;
	import czs_pkg::*;

	localparam int COLS_TOP      = MAX_COLS_DEF;
	localparam int ROWS_TOP      = MAX_ROWS_DEF;
	localparam int RANDOM_CELLS  = 450;
	localparam int HOLD_CYCLES   = 80;
	localparam int QUIET_LIMIT   = 1000;

	logic clk = 1'b0;
	logic arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	czs_in_if  grid_if();
	czs_out_if count_if();

	count_zero_squares_stream u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.grid_in   (grid_if),
		.count_out (count_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	// Grid words waiting to be sent and result words still to come.
	bit          cells_pending[$];
	czs_result_t counts_expected[$];

	// Idling controls set per phase by the stimulus.
	bit in_gaps_on    = 1'b1;
	bit out_stalls_on = 1'b1;
	int hold_requests = 0;
	int fails         = 0;

	// Predictor state: previous row per column, row state and frame position.
	logic [CNT_W-1:0]   prev_row_squares [COLS_TOP];
	logic [CNT_W-1:0]   prev_row_up_run  [COLS_TOP];
	logic [CNT_W-1:0]   above_left_squares = '0;
	logic [CNT_W-1:0]   left_run_here      = '0;
	int unsigned        row_at   = 0;
	int unsigned        col_at   = 0;
	logic [TOTAL_W-1:0] frame_sum = '0;
	int unsigned        rows_eff = ROWS_TOP;
	int unsigned        cols_eff = COLS_TOP;

	// Register value to grid size; zero means one, overlarge means the maximum.
	function automatic int unsigned reg_to_size(input logic [CFG_W-1:0] v,
			input int unsigned top);
		if (v == '0) return 1;
		if (v > top) return top;
		return 32'(v);
	endfunction

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// Square count for one grid word; advances the predictor state.
	function automatic czs_result_t predict_squares(input bit dmg);
		logic [CNT_W-1:0] up_sq, up_run, diag, left, here, run_up, run_left, m;
		int unsigned      col;
		bit               last_col, last_row;
		czs_result_t      r;
		up_sq = '0;
		up_run = '0;
		diag = '0;
		left = '0;
		here = '0;
		run_up = '0;
		run_left = '0;
		col = col_at % COLS_TOP;
		last_col = (col_at + 1 >= cols_eff);
		last_row = (row_at + 1 >= rows_eff);
		if (row_at > 0) begin
			up_sq = prev_row_squares[col];
			up_run = prev_row_up_run[col];
			if (col_at > 0) diag = above_left_squares;
		end
		if (col_at > 0) left = left_run_here;
		if (!dmg) begin
			m = (diag < up_run) ? diag : up_run;
			m = (left < m) ? left : m;
			here = bump(m);
			run_up = bump(up_run);
			run_left = bump(left);
		end
		above_left_squares = up_sq;
		prev_row_squares[col] = here;
		prev_row_up_run[col] = run_up;
		left_run_here = run_left;
		frame_sum += TOTAL_W'(here);
		r.squares_here = here;
		r.running_total = frame_sum;
		r.frame_done = last_col && last_row;
		// Row and frame wrap.
		if (last_col) begin
			col_at = 0;
			left_run_here = '0;
			above_left_squares = '0;
			if (last_row) begin
				row_at = 0;
				frame_sum = '0;
			end else begin
				row_at++;
			end
		end else begin
			col_at++;
		end
		return r;
	endfunction

	// Number of words from the current position to the end of the frame.
	function automatic int cells_to_frame_end();
		int unsigned r, c;
		int          n;
		r = row_at;
		c = col_at;
		n = 1;
		while (!(c + 1 >= cols_eff && r + 1 >= rows_eff)) begin
			if (c + 1 >= cols_eff) begin
				c = 0;
				r++;
			end else begin
				c++;
			end
			n++;
		end
		return n;
	endfunction

	// Gap length: mostly none or short, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [CFG_W-1:0] small_size_reg(input int top);
		if ($urandom_range(0, 99) < 8) return '0;
		return CFG_W'($urandom_range(1, top));
	endfunction

	// Size register value that may be at or beyond the maximum.
	function automatic logic [CFG_W-1:0] any_size_reg();
		if ($urandom_range(0, 3) != 0) return small_size_reg(8);
		case ($urandom_range(0, 4))
			0: return CFG_W'(COLS_TOP - 1);
			1: return CFG_W'(COLS_TOP);
			2: return CFG_W'(COLS_TOP + 1);
			3: return '1;
			default: return CFG_W'($urandom_range(COLS_TOP, 4095));
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ROWS) rows_eff = reg_to_size(val, ROWS_TOP);
		else cols_eff = reg_to_size(val, COLS_TOP);
	endtask

	task automatic queue_cells(input int n, input int dmg_pct);
		repeat (n) cells_pending.push_back($urandom_range(0, 99) < dmg_pct);
	endtask

	// Waits until every word is sent and every result word has come back.
	task automatic wait_idle();
		while (cells_pending.size() != 0 || grid_if.valid || counts_expected.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Grid word driver; predicts each word as it is taken.
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_if.valid <= 1'b0;
			grid_if.damaged <= 1'b0;
			send_gap = 0;
		end else begin
			if (grid_if.valid && grid_if.ready) begin
				counts_expected.push_back(predict_squares(grid_if.damaged));
			end
			if (!grid_if.valid || grid_if.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					grid_if.valid <= 1'b0;
				end else if (cells_pending.size() > 0) begin
					grid_if.valid <= 1'b1;
					grid_if.damaged <= cells_pending.pop_front();
					if (in_gaps_on) send_gap = pick_gap();
				end else begin
					grid_if.valid <= 1'b0;
				end
			end
		end
	end

	// Result word monitor with random stalls and requested long holds.
	int          stall_left;
	int          hold_left;
	int          holds_seen;
	czs_result_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_if.ready <= 1'b0;
			stall_left = 0;
			hold_left = 0;
			holds_seen = 0;
		end else begin
			if (count_if.valid && count_if.ready) begin
				if (counts_expected.size() == 0) begin
					$error("result word with no grid word pending: squares_here %0d",
						count_if.squares_here);
					fails++;
				end else begin
					want = counts_expected.pop_front();
					if (count_if.squares_here !== want.squares_here) begin
						$error("squares_here: expected %0d, got %0d",
							want.squares_here, count_if.squares_here);
						fails++;
					end
					if (count_if.running_total !== want.running_total) begin
						$error("running_total: expected %0d, got %0d",
							want.running_total, count_if.running_total);
						fails++;
					end
					if (count_if.frame_done !== want.frame_done) begin
						$error("frame_done: expected %0d, got %0d",
							want.frame_done, count_if.frame_done);
						fails++;
					end
				end
			end
			if (holds_seen != hold_requests) begin
				holds_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				count_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				count_if.ready <= 1'b0;
			end else begin
				count_if.ready <= 1'b1;
				if (out_stalls_on) stall_left = pick_gap();
			end
		end
	end

	// Watchdog on cycles with no word moved and no register written.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((grid_if.valid && grid_if.ready) || (count_if.valid && count_if.ready)
					|| cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// Stimulus.
	initial begin
		int          kind;
		int          dmg_pct;
		int          random_sent;
		int          k;
		longint      fsize;
		bit          cols_first;
		bit          change_cols;
		logic [CFG_W-1:0] rv, cv;
		random_sent = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_ROWS;
		cfg_wdata <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero registers act as a one-cell grid: one intact, one damaged cell.
		write_reg(REG_ROWS, '0);
		write_reg(REG_COLS, '0);
		cells_pending.push_back(1'b0);
		cells_pending.push_back(1'b1);
		wait_idle();

		// A 3x3 grid all intact, then with the center damaged.
		write_reg(REG_ROWS, CFG_W'(3));
		write_reg(REG_COLS, CFG_W'(3));
		repeat (9) cells_pending.push_back(1'b0);
		for (int i = 0; i < 9; i++) cells_pending.push_back(i == 4);
		wait_idle();

		// An oversized row register and full-width columns, then a shrink mid-frame ends the row early.
		write_reg(REG_ROWS, '1);
		write_reg(REG_COLS, CFG_W'(COLS_TOP));
		repeat (2) cells_pending.push_back(1'b0);
		wait_idle();
		write_reg(REG_COLS, CFG_W'(1));
		write_reg(REG_ROWS, CFG_W'(2));
		repeat (cells_to_frame_end()) cells_pending.push_back(1'b0);
		wait_idle();

		// Long hold on the result side while the sender keeps offering words.
		write_reg(REG_ROWS, CFG_W'(6));
		write_reg(REG_COLS, CFG_W'(8));
		in_gaps_on = 1'b0;
		hold_requests++;
		queue_cells(48, 10);
		random_sent += 48;
		wait_idle();

		// Random phases, each ending on a frame boundary.
		while (random_sent < RANDOM_CELLS) begin
			kind = $urandom_range(0, 9);
			in_gaps_on = ($urandom_range(0, 3) != 0);
			out_stalls_on = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 4))
				0: dmg_pct = 0;
				1: dmg_pct = 3;
				2: dmg_pct = 10;
				3: dmg_pct = 30;
				default: dmg_pct = 70;
			endcase
			if (kind < 7) begin
				// Whole frames of small sizes, some long and thin.
				if (kind == 5) begin
					rv = CFG_W'($urandom_range(1, 2));
					cv = CFG_W'($urandom_range(9, 40));
				end else if (kind == 6) begin
					rv = CFG_W'($urandom_range(9, 30));
					cv = CFG_W'($urandom_range(1, 2));
				end else begin
					rv = small_size_reg(6);
					cv = small_size_reg(8);
				end
				if ($urandom_range(0, 1)) begin
					write_reg(REG_ROWS, rv);
					write_reg(REG_COLS, cv);
				end else begin
					write_reg(REG_COLS, cv);
					write_reg(REG_ROWS, rv);
				end
				k = rows_eff * cols_eff;
				queue_cells(k, dmg_pct);
				random_sent += k;
			end else begin
				// Part of a possibly huge frame, then a resize that ends it soon.
				write_reg(REG_ROWS, any_size_reg());
				write_reg(REG_COLS, any_size_reg());
				fsize = longint'(rows_eff) * longint'(cols_eff);
				if (fsize < 2) begin
					queue_cells(1, dmg_pct);
					random_sent += 1;
				end else begin
					k = $urandom_range(1, (fsize - 1 > 40) ? 40 : int'(fsize - 1));
					queue_cells(k, dmg_pct);
					random_sent += k;
					wait_idle();
					rv = CFG_W'($urandom_range(0, 4));
					cv = small_size_reg(6);
					// Columns may only grow while the first row is in progress.
					if (row_at != 0 && reg_to_size(cv, COLS_TOP) > cols_eff)
						cv = CFG_W'(cols_eff);
					cols_first = $urandom_range(0, 1);
					// Wide rows are always narrowed so the frame ends soon.
					change_cols = ($urandom_range(0, 2) != 0) || (cols_eff > 8);
					if (change_cols && cols_first) write_reg(REG_COLS, cv);
					write_reg(REG_ROWS, rv);
					if (change_cols && !cols_first) write_reg(REG_COLS, cv);
					k = cells_to_frame_end();
					queue_cells(k, dmg_pct);
					random_sent += k;
				end
			end
			wait_idle();
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (fails == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/czs_pkg.sv
rtl/core/czs_if.sv
rtl/core/czs_ram.sv
rtl/core/czs_cell.sv
rtl/core/count_zero_squares_stream.sv
verif/tb_count_zero_squares_stream.sv
